// ----- hdl/tbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Tone burst segmenter package
// Shared types and constants for the tone burst segmenter.
// ----------------------------------------------------------------------------
package tbs_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned IndexW  = 32;
  localparam int unsigned GapW    = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgThreshold = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgGapLimit  = 1'b1;

  // Register reset values.
  localparam logic signed [SampleW-1:0] ThresholdReset = 16'sd16384;
  localparam logic [GapW-1:0]           GapLimitReset  = 16'd350;

  localparam logic [IndexW-1:0] IndexMax = '1;

  // Peak decision handed from the detector to the burst tracker.
  typedef struct packed {
    logic              peak;
    logic [IndexW-1:0] index;
    logic              fin;
  } peak_t;

  // One result item.
  typedef struct packed {
    logic [IndexW-1:0] mark_start;
    logic [IndexW-1:0] mark_end;
    logic [IndexW-1:0] mark_length;
    logic [IndexW-1:0] space_length;
    logic              has_space;
  } result_t;

endpackage

// ----- hdl/tbs_if.sv -----
// ----------------------------------------------------------------------------
// Tone burst segmenter channels
// Valid/ready channels for audio samples in and burst results out.
// ----------------------------------------------------------------------------
interface tbs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tbs_pkg::SampleW-1:0]  sample;
  logic                                final_req;

  modport source (output valid, output sample, output final_req, input ready);
  modport sink (input valid, input sample, input final_req, output ready);
endinterface

interface tbs_out_if;
  logic                              valid;
  logic                              ready;
  logic [tbs_pkg::IndexW-1:0]        mark_start;
  logic [tbs_pkg::IndexW-1:0]        mark_end;
  logic [tbs_pkg::IndexW-1:0]        mark_length;
  logic [tbs_pkg::IndexW-1:0]        space_length;
  logic                              has_space;

  modport source (output valid, output mark_start, output mark_end, output mark_length,
                  output space_length, output has_space, input ready);
  modport sink (input valid, input mark_start, input mark_end, input mark_length,
                input space_length, input has_space, output ready);
endinterface

// ----- hdl/tbs_peak_detect.sv -----
// ----------------------------------------------------------------------------
// Tone burst segmenter peak detector
// Keeps the two previous samples and the sample index, and flags a strict
// local maximum above the threshold one sample late.
// ----------------------------------------------------------------------------
module tbs_peak_detect (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic signed [tbs_pkg::SampleW-1:0] sample_i,
  input  logic                               final_i,
  input  logic signed [tbs_pkg::SampleW-1:0] threshold_i,
  output tbs_pkg::peak_t                     peak_o
);

  logic signed [tbs_pkg::SampleW-1:0] older_q, older_d;
  logic signed [tbs_pkg::SampleW-1:0] newer_q, newer_d;
  logic [tbs_pkg::IndexW-1:0]         index_q, index_d;

  always_comb begin
    peak_o.peak  = (index_q >= tbs_pkg::IndexW'(2)) && (newer_q > threshold_i) &&
                   (newer_q > older_q) && (newer_q > sample_i);
    peak_o.index = index_q - tbs_pkg::IndexW'(1);
    peak_o.fin   = final_i;
  end

  always_comb begin
    older_d = older_q;
    newer_d = newer_q;
    index_d = index_q;
    if (en_i) begin
      if (final_i) begin
        // End of stream: the next sample starts over at index zero.
        older_d = '0;
        newer_d = '0;
        index_d = '0;
      end else begin
        older_d = newer_q;
        newer_d = sample_i;
        if (index_q != tbs_pkg::IndexMax) begin
          index_d = index_q + tbs_pkg::IndexW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= '0;
      newer_q <= '0;
      index_q <= '0;
    end else begin
      older_q <= older_d;
      newer_q <= newer_d;
      index_q <= index_d;
    end
  end

endmodule

// ----- hdl/tbs_burst_track.sv -----
// ----------------------------------------------------------------------------
// Tone burst segmenter burst tracker
// Joins nearby peaks into bursts and forms one result when a burst closes.
// ----------------------------------------------------------------------------
module tbs_burst_track (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  tbs_pkg::peak_t               peak_i,
  input  logic [tbs_pkg::GapW-1:0]     gap_limit_i,
  output logic                         emit_o,
  output tbs_pkg::result_t             result_o
);

  logic [tbs_pkg::IndexW-1:0] last_peak_q, last_peak_d;
  logic                       have_peak_q, have_peak_d;
  logic                       open_q, open_d;
  logic [tbs_pkg::IndexW-1:0] start_q, start_d;
  logic [tbs_pkg::IndexW-1:0] prev_end_q, prev_end_d;
  logic                       have_prev_q, have_prev_d;

  logic [tbs_pkg::IndexW-1:0] spacing;
  logic                       join_peak;
  logic                       gap_emit;
  logic                       fin_emit;
  logic                       open_n;
  logic [tbs_pkg::IndexW-1:0] start_n;
  logic [tbs_pkg::IndexW-1:0] last_n;
  logic [tbs_pkg::IndexW-1:0] res_start;
  logic [tbs_pkg::IndexW-1:0] res_end;

  always_comb begin
    spacing   = peak_i.index - last_peak_q;
    join_peak = peak_i.peak && have_peak_q &&
                (spacing <= {{(tbs_pkg::IndexW - tbs_pkg::GapW){1'b0}}, gap_limit_i});
    // A wide gap closes the open burst with the peaks seen so far.
    gap_emit  = peak_i.peak && have_peak_q && !join_peak && open_q;

    open_n  = open_q;
    start_n = start_q;
    if (join_peak) begin
      open_n = 1'b1;
      if (!open_q) begin
        start_n = last_peak_q;
      end
    end else if (gap_emit) begin
      open_n = 1'b0;
    end
    last_n = peak_i.peak ? peak_i.index : last_peak_q;

    // The last sample flushes a burst that is still open after this sample.
    fin_emit = peak_i.fin && open_n;
    emit_o   = gap_emit || fin_emit;

    res_start = gap_emit ? start_q : start_n;
    res_end   = gap_emit ? last_peak_q : last_n;

    result_o.mark_start   = res_start;
    result_o.mark_end     = res_end;
    result_o.mark_length  = res_end - res_start;
    result_o.space_length = have_prev_q ? (res_start - prev_end_q) : '0;
    result_o.has_space    = have_prev_q;
  end

  always_comb begin
    last_peak_d = last_peak_q;
    have_peak_d = have_peak_q;
    open_d      = open_q;
    start_d     = start_q;
    prev_end_d  = prev_end_q;
    have_prev_d = have_prev_q;
    if (en_i) begin
      if (peak_i.fin) begin
        last_peak_d = '0;
        have_peak_d = 1'b0;
        open_d      = 1'b0;
        start_d     = '0;
        prev_end_d  = '0;
        have_prev_d = 1'b0;
      end else begin
        last_peak_d = last_n;
        have_peak_d = have_peak_q || peak_i.peak;
        open_d      = open_n;
        start_d     = start_n;
        if (gap_emit) begin
          prev_end_d  = res_end;
          have_prev_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_peak_q <= '0;
      have_peak_q <= 1'b0;
      open_q      <= 1'b0;
      start_q     <= '0;
      prev_end_q  <= '0;
      have_prev_q <= 1'b0;
    end else begin
      last_peak_q <= last_peak_d;
      have_peak_q <= have_peak_d;
      open_q      <= open_d;
      start_q     <= start_d;
      prev_end_q  <= prev_end_d;
      have_prev_q <= have_prev_d;
    end
  end

  a_open_has_peak : assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> have_peak_q)
    else $error("burst open without a recorded peak");

  a_start_before_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (start_q <= last_peak_q))
    else $error("burst start lies after its last peak");

  a_start_after_prev : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_q && have_prev_q) |-> (prev_end_q <= start_q))
    else $error("burst starts before the previous burst ended");

  a_emit_needs_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o && !peak_i.fin) |-> open_q)
    else $error("result formed without an open burst");

endmodule

// ----- hdl/tbs_out_reg.sv -----
// ----------------------------------------------------------------------------
// Tone burst segmenter result register
// Holds one result until the sink takes it; frees itself in the same cycle.
// ----------------------------------------------------------------------------
module tbs_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              emit_i,
  input  tbs_pkg::result_t  result_i,
  output logic              free_o,
  tbs_out_if.source         out_if_o
);

  logic             valid_q, valid_d;
  tbs_pkg::result_t data_q, data_d;

  assign free_o = !valid_q || out_if_o.ready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load_i) begin
      valid_d = emit_i;
      if (emit_i) begin
        data_d = result_i;
      end
    end else if (out_if_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_if_o.valid        = valid_q;
  assign out_if_o.mark_start   = data_q.mark_start;
  assign out_if_o.mark_end     = data_q.mark_end;
  assign out_if_o.mark_length  = data_q.mark_length;
  assign out_if_o.space_length = data_q.space_length;
  assign out_if_o.has_space    = data_q.has_space;

endmodule

// ----- hdl/tone_burst_segmenter.sv -----
// ----------------------------------------------------------------------------
// Tone burst segmenter
// Finds tone bursts in a stream of audio samples and reports each burst.
// ----------------------------------------------------------------------------
//
//  Channel    Direction  Transaction carries
//  ---------  ---------  ---------------------------------------------------
//  in_if_i    sink       sample (signed 16 bits), final_req
//  out_if_o   source     mark_start, mark_end, mark_length, space_length,
//                        has_space
//  cfg        write      cfg_idx_i 0: threshold, 1: gap_limit
//
//  Every sample is handled in one cycle and a new sample may be taken every
//  cycle; the result, if any, is visible in the cycle after its sample is taken.
//  The one result register sets the figure: a sample is taken whenever that
//  register is empty or being read in the same cycle.
//  Reset clears all stream state and loads threshold 16384, gap limit 350.
//  A stall on the result side stops intake only while a result is waiting.
//
// A sample is judged as a peak when its successor arrives: it must lie
// strictly above the threshold and strictly above both neighbors, and at
// least one earlier sample of the stream must have been seen. Peaks whose
// spacing is within the gap limit join into one burst; a burst opens only
// when the second such peak arrives. A wider gap, or the final sample of the
// stream, closes the burst and produces one result transaction. After the
// final sample all stream state returns to its reset value, while the two
// configuration registers keep their values. The sample index saturates at
// its all-ones value.
//
module tone_burst_segmenter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tbs_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [tbs_pkg::CfgW-1:0]        cfg_wdata_i,
  tbs_in_if.sink                          in_if_i,
  tbs_out_if.source                       out_if_o
);

  logic signed [tbs_pkg::SampleW-1:0] threshold_q, threshold_d;
  logic [tbs_pkg::GapW-1:0]           gap_limit_q, gap_limit_d;

  logic             accept;
  logic             free;
  logic             emit;
  tbs_pkg::peak_t   peak;
  tbs_pkg::result_t result;

  // Configuration registers; the user must write them only while the block is idle; the block does not enforce this.
  always_comb begin
    threshold_d = threshold_q;
    gap_limit_d = gap_limit_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tbs_pkg::CfgThreshold: threshold_d = cfg_wdata_i;
        tbs_pkg::CfgGapLimit:  gap_limit_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= tbs_pkg::ThresholdReset;
      gap_limit_q <= tbs_pkg::GapLimitReset;
    end else begin
      threshold_q <= threshold_d;
      gap_limit_q <= gap_limit_d;
    end
  end

  // The input side is ready whenever the result register can take a new
  // value in this cycle.
  assign in_if_i.ready = free;
  assign accept        = in_if_i.valid && free;

  tbs_peak_detect u_peak (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (accept),
    .sample_i    (in_if_i.sample),
    .final_i     (in_if_i.final_req),
    .threshold_i (threshold_q),
    .peak_o      (peak)
  );

  tbs_burst_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (accept),
    .peak_i      (peak),
    .gap_limit_i (gap_limit_q),
    .emit_o      (emit),
    .result_o    (result)
  );

  tbs_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .emit_i   (emit),
    .result_i (result),
    .free_o   (free),
    .out_if_o (out_if_o)
  );

endmodule

// ----- tb/tb_tone_burst_segmenter.sv -----
// ----------------------------------------------------------------------------
// Tone burst segmenter testbench
// Streams audio samples into the segmenter and checks every reported burst
// against a cycle-free model of peak finding and burst joining kept in this
// file. Directed streams cover the stream edges, the final flush and the
// register extremes. Random streams with random gaps on both channels,
// a long receiver hold-off and a mid-stream drain follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_tone_burst_segmenter;

  typedef logic signed [tbs_pkg::SampleW-1:0] sample_t;

  // Cycles allowed after the last expected mark before the block counts as
  // quiet. A sample that closes nothing leaves no trace on the result side,
  // so this covers the registered result with some margin.
  localparam int unsigned SettleCycles = 6;
  // Length of the receiver hold-off used to back the block up.
  localparam int unsigned HoldCycles   = 60;
  // Hard stop for a hung run, far beyond the slowest legal run.
  localparam int unsigned TimeoutNs    = 4_000_000;
  localparam int unsigned RandomItems  = 300;

  logic clk;
  logic rst_n;
  logic                         cfg_we;
  logic [tbs_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [tbs_pkg::CfgW-1:0]     cfg_wdata;

  tbs_in_if  samples_if ();
  tbs_out_if marks_if ();

  tone_burst_segmenter dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_if_i    (samples_if),
    .out_if_o   (marks_if)
  );

  // --------------------------------------------------------------------------
  // Segmenter model: a private copy of the registers and the stream state.
  // --------------------------------------------------------------------------
  sample_t                      thr_m;
  logic [tbs_pkg::GapW-1:0]     gap_m;
  sample_t                      older_m;
  sample_t                      newer_m;
  logic [tbs_pkg::IndexW-1:0]   idx_m;
  logic [tbs_pkg::IndexW-1:0]   last_peak_m;
  logic                         have_peak_m;
  logic                         open_m;
  logic [tbs_pkg::IndexW-1:0]   start_m;
  logic [tbs_pkg::IndexW-1:0]   prev_end_m;
  logic                         have_prev_m;

  // Marks that the model has predicted and the block has not yet delivered.
  tbs_pkg::result_t pending_marks[$];

  // Bookkeeping for the checker and the summary.
  int unsigned failures;
  int unsigned marks_seen;
  int unsigned samples_sent;
  int unsigned streams_sent;
  int unsigned settings_used;

  // Idle control: percent chance per transaction (sender) or per cycle
  // (receiver) that a gap starts.
  int unsigned      in_gap_pct;
  int unsigned      out_stall_pct;
  int unsigned      stall_left;
  int unsigned      hold_left;
  int unsigned      hold_reqs;
  int unsigned      hold_seen;
  tbs_pkg::result_t got_mark;
  tbs_pkg::result_t want_mark;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Returns the stream state to its reset value, as after a final sample.
  function automatic void clear_stream();
    older_m     = '0;
    newer_m     = '0;
    idx_m       = '0;
    last_peak_m = '0;
    have_peak_m = 1'b0;
    open_m      = 1'b0;
    start_m     = '0;
    prev_end_m  = '0;
    have_prev_m = 1'b0;
  endfunction

  // Closes the open burst and fills in the mark that reports it.
  function automatic void close_burst(output tbs_pkg::result_t mark);
    mark.mark_start   = start_m;
    mark.mark_end     = last_peak_m;
    mark.mark_length  = last_peak_m - start_m;
    mark.space_length = have_prev_m ? start_m - prev_end_m : '0;
    mark.has_space    = have_prev_m;
    prev_end_m  = last_peak_m;
    have_prev_m = 1'b1;
    open_m      = 1'b0;
  endfunction

  // Advances the model by one sample. Returns 1 when the sample closes a
  // burst, with the mark in 'mark'.
  function automatic bit segment_sample(input sample_t cur, input logic fin,
                                        output tbs_pkg::result_t mark);
    bit                         closed;
    logic [tbs_pkg::IndexW-1:0] peak_idx;
    closed = 1'b0;
    mark   = '0;
    // The previous sample is judged now that its right neighbor is here.
    if (idx_m >= 2 && newer_m > thr_m && newer_m > older_m && newer_m > cur) begin
      peak_idx = idx_m - 1;
      if (have_peak_m) begin
        if (peak_idx - last_peak_m <=
            {{(tbs_pkg::IndexW-tbs_pkg::GapW){1'b0}}, gap_m}) begin
          // A second peak close enough opens the burst at the earlier one.
          if (!open_m) begin
            open_m  = 1'b1;
            start_m = last_peak_m;
          end
        end else if (open_m) begin
          close_burst(mark);
          closed = 1'b1;
        end
      end
      last_peak_m = peak_idx;
      have_peak_m = 1'b1;
    end
    older_m = newer_m;
    newer_m = cur;
    if (idx_m != tbs_pkg::IndexMax) idx_m++;
    // The final sample flushes an open burst unless a gap already closed it.
    if (fin) begin
      if (open_m && !closed) begin
        close_burst(mark);
        closed = 1'b1;
      end
      clear_stream();
    end
    return closed;
  endfunction

  // Gap length: none most of the time, short ones often, long ones rarely.
  function automatic int unsigned pick_gap(input int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // A level strictly above the current threshold, or the top level when
  // nothing can exceed it.
  function automatic sample_t peak_level();
    int lo;
    lo = int'(thr_m) + 1;
    if (lo > 32767) return sample_t'(32767);
    return sample_t'(lo + int'($urandom_range(0, 32767 - lo)));
  endfunction

  // A level at or below the threshold, now and then plain random noise.
  function automatic sample_t quiet_level();
    if ($urandom_range(9) == 0) return sample_t'($urandom);
    return sample_t'(int'($urandom_range(0, int'(thr_m) + 32768)) - 32768);
  endfunction

  function automatic void report_mark(input string what, input tbs_pkg::result_t want,
                                      input tbs_pkg::result_t got);
    failures++;
    if (failures <= 10) begin
      $display("%0t %s: expected start=%0d end=%0d len=%0d space=%0d has=%0b,",
               $realtime, what, want.mark_start, want.mark_end, want.mark_length,
               want.space_length, want.has_space);
      $display("    got start=%0d end=%0d len=%0d space=%0d has=%0b",
               got.mark_start, got.mark_end, got.mark_length, got.space_length,
               got.has_space);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offers one sample, waits for its transaction and predicts.
  // Valid stays high into the next call so back-to-back samples are not
  // lowered and raised in the same step.
  // --------------------------------------------------------------------------
  task automatic send_sample(input sample_t value, input logic fin);
    int unsigned      gap;
    tbs_pkg::result_t mark;
    gap = pick_gap(in_gap_pct);
    if (gap != 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid     <= 1'b1;
    samples_if.sample    <= value;
    samples_if.final_req <= fin;
    do @(posedge clk); while (!samples_if.ready);
    samples_sent++;
    if (fin) streams_sent++;
    if (segment_sample(value, fin, mark)) pending_marks.insert(pending_marks.size(), mark);
  endtask

  // Stops offering samples until every predicted mark has arrived, then lets
  // the block settle.
  task automatic drain_marks();
    samples_if.valid <= 1'b0;
    while (pending_marks.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // One register write. Only called while the block is quiet.
  task automatic write_reg(input logic [tbs_pkg::CfgIdxW-1:0] idx,
                           input logic [tbs_pkg::CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tbs_pkg::CfgThreshold: thr_m = sample_t'(data);
      default:               gap_m = data;
    endcase
    @(posedge clk);
  endtask

  task automatic set_registers(input logic [tbs_pkg::CfgW-1:0] thr,
                               input logic [tbs_pkg::CfgW-1:0] gap);
    write_reg(tbs_pkg::CfgThreshold, thr);
    write_reg(tbs_pkg::CfgGapLimit, gap);
    settings_used++;
  endtask

  // Sends a fixed sample sequence; the last sample ends the stream.
  task automatic play_fixed(input int seq[$]);
    foreach (seq[i]) send_sample(sample_t'(seq[i]), i == seq.size() - 1);
  endtask

  // Sends a stream of peaks whose spacing is mostly within the gap limit and
  // sometimes just beyond it, so bursts open and close in turn.
  task automatic play_stream(input int unsigned peaks, input bit fin);
    int unsigned near_hi;
    int unsigned far_hi;
    int unsigned spacing;
    near_hi = (gap_m < 12) ? gap_m : 12;
    if (near_hi < 2) near_hi = 2;
    far_hi = near_hi + $urandom_range(1, 8);
    repeat ($urandom_range(1, 2)) send_sample(quiet_level(), 1'b0);
    repeat (peaks) begin
      spacing = ($urandom_range(9) < 7) ? $urandom_range(2, near_hi)
                                        : $urandom_range(near_hi + 1, far_hi);
      send_sample(peak_level(), 1'b0);
      repeat (spacing - 1) send_sample(quiet_level(), 1'b0);
    end
    if (fin) send_sample(sample_t'($urandom), 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset register values. The first sample is full scale but can never be a
  // peak, nor can the high final sample; the two peaks in between form one
  // burst that the final sample flushes with no space before it.
  task automatic test_reset_settings();
    int seq[$];
    seq = '{32767, -32768, 20000, -5, 30000, 0, 32767};
    play_fixed(seq);
  endtask

  // A wide gap closes a burst, the next burst reports the space since the
  // first, and in the last step a gap and the final sample coincide, which
  // must yield only one mark.
  task automatic test_gap_and_final();
    int seq[$];
    drain_marks();
    set_registers(16'h0000, 16'd2);
    seq = '{0, 5, 0, 5, 0, 0, 5, 0, 5, 0, 0, 0, 9, 0};
    play_fixed(seq);
  endtask

  // Lowest threshold with a gap limit of zero: peaks at the bottom of the
  // range are found but never join, so no mark may appear.
  task automatic test_threshold_extremes();
    int seq[$];
    drain_marks();
    set_registers(16'h8000, 16'd0);
    seq = '{-32768, -32767, -32768, -32767, -32768};
    play_fixed(seq);
  endtask

  // The receiver holds off while short bursts keep closing, so the result
  // register fills and intake stalls. Halfway the sender pauses mid-stream,
  // with its last peak not yet judged, until every mark is in.
  task automatic test_backpressure();
    drain_marks();
    set_registers(16'h0000, 16'd2);
    in_gap_pct    = 0;
    out_stall_pct = 0;
    hold_reqs++;
    repeat (8) begin
      send_sample(sample_t'(1000), 1'b0);
      send_sample(sample_t'(-1000), 1'b0);
      send_sample(sample_t'(1000), 1'b0);
      repeat (3) send_sample(sample_t'(-1000), 1'b0);
    end
    send_sample(sample_t'(1000), 1'b0);
    send_sample(sample_t'(-1000), 1'b0);
    send_sample(sample_t'(1000), 1'b0);
    drain_marks();
    repeat (3) begin
      repeat (3) send_sample(sample_t'(-1000), 1'b0);
      send_sample(sample_t'(1000), 1'b0);
      send_sample(sample_t'(-1000), 1'b0);
      send_sample(sample_t'(1000), 1'b0);
    end
    send_sample(sample_t'(-1000), 1'b1);
  endtask

  // Random register settings, extremes included, with random streams.
  // Every fourth phase runs without idling on either side.
  task automatic test_random_streams();
    int unsigned              goal;
    int unsigned              phase;
    int unsigned              pick;
    logic [tbs_pkg::CfgW-1:0] thr;
    logic [tbs_pkg::CfgW-1:0] gap;
    goal  = samples_sent + RandomItems;
    phase = 0;
    while (samples_sent < goal) begin
      drain_marks();
      pick = $urandom_range(9);
      if (pick == 0) thr = 16'h8000;
      else if (pick == 1) thr = 16'h7FFF;
      else if (pick < 6) thr = tbs_pkg::CfgW'(int'($urandom_range(0, 20000)) - 10000);
      else thr = tbs_pkg::CfgW'($urandom);
      pick = $urandom_range(9);
      if (pick == 0) gap = 16'd1;
      else if (pick == 1) gap = 16'hFFFF;
      else gap = tbs_pkg::CfgW'($urandom_range(2, 10));
      set_registers(thr, gap);
      if (phase % 4 == 0) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct    = $urandom_range(15, 40);
        out_stall_pct = $urandom_range(15, 40);
      end
      // Now and then a stream runs on into the next phase unfinished.
      repeat ($urandom_range(1, 3))
        play_stream($urandom_range(2, 12), $urandom_range(9) != 0);
      phase++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: checks each result transaction against the oldest prediction
  // and drives ready with random stalls and the requested hold-off.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (marks_if.valid && marks_if.ready) begin
        got_mark.mark_start   = marks_if.mark_start;
        got_mark.mark_end     = marks_if.mark_end;
        got_mark.mark_length  = marks_if.mark_length;
        got_mark.space_length = marks_if.space_length;
        got_mark.has_space    = marks_if.has_space;
        marks_seen++;
        if (pending_marks.size() == 0) begin
          report_mark("mark with none expected", '0, got_mark);
        end else begin
          want_mark = pending_marks.pop_front();
          if (got_mark !== want_mark) report_mark("mark mismatch", want_mark, got_mark);
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        marks_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        marks_if.ready <= 1'b0;
      end else begin
        stall_left = pick_gap(out_stall_pct);
        marks_if.ready <= (stall_left == 0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = tbs_pkg::CfgThreshold;
    cfg_wdata            = '0;
    samples_if.valid     = 1'b0;
    samples_if.sample    = '0;
    samples_if.final_req = 1'b0;
    marks_if.ready       = 1'b0;
    failures      = 0;
    marks_seen    = 0;
    samples_sent  = 0;
    streams_sent  = 0;
    settings_used = 1;
    in_gap_pct    = 0;
    out_stall_pct = 0;
    stall_left    = 0;
    hold_left     = 0;
    hold_reqs     = 0;
    hold_seen     = 0;
    thr_m = tbs_pkg::ThresholdReset;
    gap_m = tbs_pkg::GapLimitReset;
    clear_stream();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_gap_and_final();
    test_threshold_extremes();
    test_backpressure();
    test_random_streams();

    // Let every outstanding mark arrive, then watch for strays.
    drain_marks();
    $display("Sent %0d samples in %0d finished streams under %0d register settings.",
             samples_sent, streams_sent, settings_used);
    $display("Checked %0d marks; %0d failures.", marks_seen, failures);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("Timeout with %0d marks outstanding.", pending_marks.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/tbs_pkg.sv
hdl/tbs_if.sv
hdl/tbs_peak_detect.sv
hdl/tbs_burst_track.sv
hdl/tbs_out_reg.sv
hdl/tone_burst_segmenter.sv
tb/tb_tone_burst_segmenter.sv
